>>> sv/gts_pkg.sv
// Shared types, character codes and classification functions of the token scanner.
package gts_pkg;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_INT    = 3'd1;
    localparam logic [2:0] MODE_FLOAT  = 3'd2;
    localparam logic [2:0] MODE_IDENT  = 3'd3;
    localparam logic [2:0] MODE_EQUALS = 3'd4;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [2:0] CLASS_NONE  = 3'd0;
    localparam logic [2:0] CLASS_INT   = 3'd0;
    localparam logic [2:0] CLASS_FLOAT = 3'd1;
    localparam logic [2:0] CLASS_OPEN  = 3'd2;
    localparam logic [2:0] CLASS_CLOSE = 3'd3;
    localparam logic [2:0] CLASS_PROD  = 3'd4;
    localparam logic [2:0] CLASS_PUNCT = 3'd5;
    localparam logic [2:0] CLASS_IDENT = 3'd6;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_EQUALS  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    localparam logic [15:0] LINE_RESET = 16'd1;
    localparam logic [15:0] LINE_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [7:0] char_value;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  token_class;
        logic [7:0]  out_char;
        logic        first_of_token;
        logic        closes_token;
        logic [1:0]  error_code;
        logic [15:0] line_number;
        logic        last_result;
    } t_out_word;

    typedef struct packed {
        t_out_word first_word;
        t_out_word second_word;
        logic      has_second;
    } t_entry;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return c inside {[8'h61:8'h7A]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_prod(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], 8'h2B, 8'h2D, 8'h26, 8'h5C, 8'h2F, 8'h2A,
                         8'h5E, 8'h7C, 8'h7B, 8'h7D, 8'h21, 8'h5B, 8'h5D};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {CH_SEMI, 8'h3A, 8'h27, 8'h2C};
    endfunction

    function automatic t_out_word mk_word(input logic [1:0] kind, input logic [2:0] cls,
                                          input logic [7:0] ch, input logic first,
                                          input logic closes, input logic [1:0] err,
                                          input logic [15:0] line);
        t_out_word w;
        w.result_kind    = kind;
        w.token_class    = cls;
        w.out_char       = ch;
        w.first_of_token = first;
        w.closes_token   = closes;
        w.error_code     = err;
        w.line_number    = line;
        w.last_result    = 1'b0;
        return w;
    endfunction

endpackage

>>> sv/grammar_token_scanner_core.sv
// Top level of the token scanner: front end, entry queue and back end.
// A character's result entry is registered in the queue, then unpacked into the output register.
// Throughput: one character per cycle while the queue is not full; a character that gives
// two words holds the output port for both words, so the port sets the sustained rate for them.
// Reset: synchronous, active low; scan mode to idle, line count to one, queue and output
// register emptied.
module grammar_token_scanner_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gts_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gts_pkg::t_out_word o_out_word
);
    import gts_pkg::*;

    logic      fire;
    logic      push;
    logic      pop;
    t_entry    push_entry;
    t_entry    head;
    t_q_status q_status;

    assign o_in_ready = !q_status.full;
    assign fire       = i_in_valid && o_in_ready;

    gts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (i_in_word),
        .o_push  (push),
        .o_entry (push_entry)
    );

    gts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    gts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

>>> sv/gts_front.sv
// Front end: accepts characters, runs the scan state machine and builds result entries.
module gts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  gts_pkg::t_in_word i_word,
    output logic              o_push,
    output gts_pkg::t_entry   o_entry
);
    import gts_pkg::*;

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_line, n_line;
    logic        r_fin, n_fin;

    logic [7:0]  c;
    t_out_word   idle_res;
    logic        idle_has;
    logic [2:0]  idle_mode;
    logic [15:0] idle_line;
    t_out_word   res0, res1;
    logic [1:0]  n_res;

    assign c = i_word.char_value;

    always_comb begin
        idle_res  = mk_word(KIND_ERROR, CLASS_NONE, c, 1'b0, 1'b0, ERR_INVALID, r_line);
        idle_has  = 1'b1;
        idle_mode = MODE_IDLE;
        idle_line = r_line;
        if (is_space(c)) begin
            idle_has = 1'b0;
            if (c == CH_LF && r_line != LINE_MAX) begin
                idle_line = r_line + 16'd1;
            end
        end else if (is_digit(c)) begin
            idle_res  = mk_word(KIND_CHAR, CLASS_INT, c, 1'b1, 1'b0, ERR_NONE, r_line);
            idle_mode = MODE_INT;
        end else if (is_lower(c)) begin
            idle_res  = mk_word(KIND_CHAR, CLASS_IDENT, c, 1'b1, 1'b0, ERR_NONE, r_line);
            idle_mode = MODE_IDENT;
        end else if (c == CH_LPAREN) begin
            idle_res = mk_word(KIND_CHAR, CLASS_OPEN, c, 1'b1, 1'b1, ERR_NONE, r_line);
        end else if (c == CH_RPAREN) begin
            idle_res = mk_word(KIND_CHAR, CLASS_CLOSE, c, 1'b1, 1'b1, ERR_NONE, r_line);
        end else if (is_prod(c)) begin
            idle_res = mk_word(KIND_CHAR, CLASS_PROD, c, 1'b1, 1'b1, ERR_NONE, r_line);
        end else if (is_punct(c)) begin
            idle_res = mk_word(KIND_CHAR, CLASS_PUNCT, c, 1'b1, 1'b1, ERR_NONE, r_line);
        end else if (c == CH_EQ) begin
            idle_res  = mk_word(KIND_CHAR, CLASS_PUNCT, c, 1'b1, 1'b0, ERR_NONE, r_line);
            idle_mode = MODE_EQUALS;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        n_fin  = r_fin;
        n_res  = 2'd0;
        res0   = mk_word(KIND_END, CLASS_NONE, CH_NUL, 1'b0, 1'b0, ERR_NONE, r_line);
        res1   = res0;
        if (r_fin) begin
            n_res = 2'd1;
        end else if (i_word.end_of_input) begin
            n_mode = MODE_IDLE;
            n_fin  = 1'b1;
            if (r_mode == MODE_IDLE) begin
                n_res = 2'd1;
            end else begin
                n_res = 2'd2;
                case (r_mode)
                    MODE_INT:    res0 = mk_word(KIND_CLOSED, CLASS_INT, CH_NUL, 1'b0, 1'b0,
                                                ERR_NONE, r_line);
                    MODE_FLOAT:  res0 = mk_word(KIND_CLOSED, CLASS_FLOAT, CH_NUL, 1'b0, 1'b0,
                                                ERR_NONE, r_line);
                    MODE_IDENT:  res0 = mk_word(KIND_CLOSED, CLASS_IDENT, CH_NUL, 1'b0, 1'b0,
                                                ERR_NONE, r_line);
                    default:     res0 = mk_word(KIND_ERROR, CLASS_NONE, CH_NUL, 1'b0, 1'b0,
                                                ERR_EQUALS, r_line);
                endcase
            end
        end else begin
            case (r_mode)
                MODE_INT, MODE_FLOAT, MODE_IDENT: begin
                    if ((r_mode != MODE_IDENT && is_digit(c))
                        || (r_mode == MODE_IDENT && is_lower(c))) begin
                        n_res = 2'd1;
                        res0  = mk_word(KIND_CHAR, (r_mode == MODE_INT) ? CLASS_INT :
                                        (r_mode == MODE_FLOAT) ? CLASS_FLOAT : CLASS_IDENT,
                                        c, 1'b0, 1'b0, ERR_NONE, r_line);
                    end else if (r_mode == MODE_INT && c == CH_DOT) begin
                        n_res  = 2'd1;
                        res0   = mk_word(KIND_CHAR, CLASS_FLOAT, c, 1'b0, 1'b0, ERR_NONE,
                                         r_line);
                        n_mode = MODE_FLOAT;
                    end else begin
                        res0   = mk_word(KIND_CLOSED, (r_mode == MODE_INT) ? CLASS_INT :
                                         (r_mode == MODE_FLOAT) ? CLASS_FLOAT : CLASS_IDENT,
                                         CH_NUL, 1'b0, 1'b0, ERR_NONE, r_line);
                        res1   = idle_res;
                        n_res  = idle_has ? 2'd2 : 2'd1;
                        n_mode = idle_mode;
                        n_line = idle_line;
                    end
                end
                MODE_EQUALS: begin
                    n_res  = 2'd1;
                    n_mode = MODE_IDLE;
                    if (c == CH_GT) begin
                        res0 = mk_word(KIND_CHAR, CLASS_PUNCT, c, 1'b0, 1'b1, ERR_NONE, r_line);
                    end else begin
                        res0 = mk_word(KIND_ERROR, CLASS_NONE, c, 1'b0, 1'b0, ERR_EQUALS,
                                       r_line);
                    end
                end
                default: begin
                    res0   = idle_res;
                    n_res  = idle_has ? 2'd1 : 2'd0;
                    n_mode = idle_mode;
                    n_line = idle_line;
                end
            endcase
        end
        if (n_res == 2'd2) begin
            res1.last_result = 1'b1;
        end else begin
            res0.last_result = 1'b1;
        end
    end

    assign o_push              = i_fire && (n_res != 2'd0);
    assign o_entry.first_word  = res0;
    assign o_entry.second_word = res1;
    assign o_entry.has_second  = (n_res == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_line <= LINE_RESET;
            r_fin  <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_fin  <= n_fin;
        end
    end

endmodule

>>> sv/gts_queue.sv
// Short queue of result entries between the front end and the back end.
module gts_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gts_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output gts_pkg::t_entry     o_head,
    output gts_pkg::t_q_status  o_status
);
    import gts_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    assign o_head             = r_mem[r_rd];
    assign o_status.full      = (r_cnt == CNT_W'(DEPTH));
    assign o_status.not_empty = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> sv/gts_back.sv
// Back end: unpacks queued entries into single result words on the output register.
module gts_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gts_pkg::t_entry     i_head,
    input  gts_pkg::t_q_status  i_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gts_pkg::t_out_word  o_out_word
);
    import gts_pkg::*;

    logic      r_valid, n_valid;
    logic      r_phase, n_phase;
    t_out_word r_word, n_word;

    always_comb begin
        n_valid = r_valid && !i_out_ready;
        n_phase = r_phase;
        n_word  = r_word;
        o_pop   = 1'b0;
        if ((!r_valid || i_out_ready) && i_status.not_empty) begin
            n_valid = 1'b1;
            if (r_phase) begin
                n_word  = i_head.second_word;
                n_phase = 1'b0;
                o_pop   = 1'b1;
            end else begin
                n_word = i_head.first_word;
                if (i_head.has_second) begin
                    n_phase = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

>>> sv/gts_checker.sv
// Port checker for the token scanner and its bind to the top level.
module gts_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input gts_pkg::t_out_word o_out_word
);
    import gts_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word dropped or changed while stalled");

    a_char_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_kind == KIND_CHAR |->
        o_out_word.error_code == ERR_NONE)
        else $error("token character carries an error code");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_kind == KIND_ERROR |->
        o_out_word.token_class == CLASS_NONE && o_out_word.error_code != ERR_NONE
        && !o_out_word.first_of_token && !o_out_word.closes_token)
        else $error("error word has inconsistent fields");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_kind == KIND_END |-> o_out_word.last_result)
        else $error("end word is not the last word of its character");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.line_number != 16'd0)
        else $error("line number is zero");

endmodule

bind grammar_token_scanner_core gts_checker u_gts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

>>> tb/tb_grammar_token_scanner_core.sv
// Testbench for the token scanner core: directed table and random token streams.
`timescale 1ns / 1ps

module tb_grammar_token_scanner_core;
    import gts_pkg::*;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 1100;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TOP   = 8'hFF;
    localparam logic [8*13-1:0] PROD_MARKS  = "+-&\\/*^|{}![]";
    localparam logic [8*4-1:0]  PUNCT_MARKS = ";:',";

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_out_word  want;
    } t_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    logic [2:0]  scan_state = MODE_IDLE;
    logic [15:0] line_now = LINE_RESET;
    logic        stream_done = 1'b0;
    t_out_word   step_words[$];
    t_out_word   pending_words[$];

    int  fail_count = 0;
    int  cycles = 0;
    int  ready_hold = 0;
    int  productive_chars = 0;
    logic no_idle = 1'b0;

    grammar_token_scanner_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic char_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic char_lower(input logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic logic char_prod(input logic [7:0] c);
        logic hit;
        hit = c >= "A" && c <= "Z";
        for (int k = 0; k < 13; k++) begin
            if (c == PROD_MARKS[8*k +: 8]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic char_punct(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (c == PUNCT_MARKS[8*k +: 8]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void put_word(input logic [1:0] kind, input logic [2:0] cls,
                                     input logic [7:0] ch, input logic first,
                                     input logic closes, input logic [1:0] err);
        t_out_word w;
        w.result_kind    = kind;
        w.token_class    = cls;
        w.out_char       = ch;
        w.first_of_token = first;
        w.closes_token   = closes;
        w.error_code     = err;
        w.line_number    = line_now;
        w.last_result    = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void scan_from_idle(input logic [7:0] c);
        scan_state = MODE_IDLE;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            if (c == CH_LF && line_now != LINE_MAX) begin
                line_now = line_now + 16'd1;
            end
        end else if (char_digit(c)) begin
            put_word(KIND_CHAR, CLASS_INT, c, 1'b1, 1'b0, ERR_NONE);
            scan_state = MODE_INT;
        end else if (char_lower(c)) begin
            put_word(KIND_CHAR, CLASS_IDENT, c, 1'b1, 1'b0, ERR_NONE);
            scan_state = MODE_IDENT;
        end else if (c == CH_LPAREN) begin
            put_word(KIND_CHAR, CLASS_OPEN, c, 1'b1, 1'b1, ERR_NONE);
        end else if (c == CH_RPAREN) begin
            put_word(KIND_CHAR, CLASS_CLOSE, c, 1'b1, 1'b1, ERR_NONE);
        end else if (char_prod(c)) begin
            put_word(KIND_CHAR, CLASS_PROD, c, 1'b1, 1'b1, ERR_NONE);
        end else if (char_punct(c)) begin
            put_word(KIND_CHAR, CLASS_PUNCT, c, 1'b1, 1'b1, ERR_NONE);
        end else if (c == CH_EQ) begin
            put_word(KIND_CHAR, CLASS_PUNCT, c, 1'b1, 1'b0, ERR_NONE);
            scan_state = MODE_EQUALS;
        end else begin
            put_word(KIND_ERROR, CLASS_NONE, c, 1'b0, 1'b0, ERR_INVALID);
        end
    endfunction

    function automatic void scan_char(input t_in_word w);
        logic [7:0] c;
        t_out_word  tail;
        c = w.char_value;
        step_words.delete();
        if (stream_done) begin
            put_word(KIND_END, CLASS_NONE, CH_NUL, 1'b0, 1'b0, ERR_NONE);
        end else if (w.end_of_input) begin
            case (scan_state)
                MODE_INT: put_word(KIND_CLOSED, CLASS_INT, CH_NUL, 1'b0, 1'b0, ERR_NONE);
                MODE_FLOAT: put_word(KIND_CLOSED, CLASS_FLOAT, CH_NUL, 1'b0, 1'b0, ERR_NONE);
                MODE_IDENT: put_word(KIND_CLOSED, CLASS_IDENT, CH_NUL, 1'b0, 1'b0, ERR_NONE);
                MODE_EQUALS: put_word(KIND_ERROR, CLASS_NONE, CH_NUL, 1'b0, 1'b0, ERR_EQUALS);
                default: ;
            endcase
            put_word(KIND_END, CLASS_NONE, CH_NUL, 1'b0, 1'b0, ERR_NONE);
            scan_state  = MODE_IDLE;
            stream_done = 1'b1;
        end else begin
            case (scan_state)
                MODE_INT: begin
                    if (char_digit(c)) begin
                        put_word(KIND_CHAR, CLASS_INT, c, 1'b0, 1'b0, ERR_NONE);
                    end else if (c == CH_DOT) begin
                        put_word(KIND_CHAR, CLASS_FLOAT, c, 1'b0, 1'b0, ERR_NONE);
                        scan_state = MODE_FLOAT;
                    end else begin
                        put_word(KIND_CLOSED, CLASS_INT, CH_NUL, 1'b0, 1'b0, ERR_NONE);
                        scan_from_idle(c);
                    end
                end
                MODE_FLOAT: begin
                    if (char_digit(c)) begin
                        put_word(KIND_CHAR, CLASS_FLOAT, c, 1'b0, 1'b0, ERR_NONE);
                    end else begin
                        put_word(KIND_CLOSED, CLASS_FLOAT, CH_NUL, 1'b0, 1'b0, ERR_NONE);
                        scan_from_idle(c);
                    end
                end
                MODE_IDENT: begin
                    if (char_lower(c)) begin
                        put_word(KIND_CHAR, CLASS_IDENT, c, 1'b0, 1'b0, ERR_NONE);
                    end else begin
                        put_word(KIND_CLOSED, CLASS_IDENT, CH_NUL, 1'b0, 1'b0, ERR_NONE);
                        scan_from_idle(c);
                    end
                end
                MODE_EQUALS: begin
                    if (c == CH_GT) begin
                        put_word(KIND_CHAR, CLASS_PUNCT, c, 1'b0, 1'b1, ERR_NONE);
                    end else begin
                        put_word(KIND_ERROR, CLASS_NONE, c, 1'b0, 1'b0, ERR_EQUALS);
                    end
                    scan_state = MODE_IDLE;
                end
                default: scan_from_idle(c);
            endcase
        end
        if (step_words.size() > 0) begin
            tail = step_words.pop_back();
            tail.last_result = 1'b1;
            step_words.push_back(tail);
        end
    endfunction

    function automatic t_out_word word_at_line_one(input logic [1:0] kind,
                                                   input logic [2:0] cls,
                                                   input logic [7:0] ch, input logic first,
                                                   input logic [1:0] err);
        return {kind, cls, ch, first, 1'b0, err, LINE_RESET, 1'b1};
    endfunction

    function automatic t_row directed_row(input int idx);
        t_row r;
        r = '0;
        case (idx)
            0: r = {"0", 1'b1, word_at_line_one(KIND_CHAR, CLASS_INT, "0", 1'b1, ERR_NONE)};
            1: r.ch = "9";
            2: r.ch = CH_DOT;
            3: r.ch = "5";
            4: r.ch = "a";
            5: r.ch = "z";
            6: r.ch = CH_LPAREN;
            7: r.ch = CH_RPAREN;
            8: r.ch = "A";
            9: r.ch = "Z";
            10: r.ch = "]";
            11: r.ch = ",";
            12: r.ch = CH_EQ;
            13: r.ch = CH_GT;
            14: r.ch = CH_EQ;
            15: r = {CH_LF, 1'b1,
                     word_at_line_one(KIND_ERROR, CLASS_NONE, CH_LF, 1'b0, ERR_EQUALS)};
            16: r = {CH_NUL, 1'b1,
                     word_at_line_one(KIND_ERROR, CLASS_NONE, CH_NUL, 1'b0, ERR_INVALID)};
            17: r = {CH_TOP, 1'b1,
                     word_at_line_one(KIND_ERROR, CLASS_NONE, CH_TOP, 1'b0, ERR_INVALID)};
            18: r.ch = "7";
            19: r.ch = CH_LF;
            20: r.ch = CH_SPACE;
            21: r.ch = CH_TAB;
            22: r.ch = "1";
            23: r.ch = CH_DOT;
            default: r.ch = CH_SEMI;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 0;
        end else if (r < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    task automatic send_word(input t_in_word w, input logic typed, input t_out_word want);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        scan_char(w);
        if (step_words.size() > 0) begin
            productive_chars++;
        end
        if (typed) begin
            pending_words.push_back(want);
        end else begin
            foreach (step_words[k]) pending_words.push_back(step_words[k]);
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        send_word({c, 1'b0}, 1'b0, '0);
    endtask

    task automatic send_token();
        int sel;
        int n;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 27) begin
            n = $urandom_range(1, sel < 15 ? 6 : 4);
            repeat (n) begin
                c = 8'("0" + $urandom_range(0, 9));
                send_char(c);
            end
            if (sel >= 15) begin
                send_char(CH_DOT);
                repeat ($urandom_range(0, 4)) begin
                    c = 8'("0" + $urandom_range(0, 9));
                    send_char(c);
                end
            end
        end else if (sel < 42) begin
            repeat ($urandom_range(1, 8)) begin
                c = 8'("a" + $urandom_range(0, 25));
                send_char(c);
            end
        end else if (sel < 55) begin
            c = 8'("A" + $urandom_range(0, 25));
            send_char(c);
        end else if (sel < 62) begin
            send_char(PROD_MARKS[8*$urandom_range(0, 12) +: 8]);
        end else if (sel < 68) begin
            send_char($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
        end else if (sel < 74) begin
            send_char(PUNCT_MARKS[8*$urandom_range(0, 3) +: 8]);
        end else if (sel < 80) begin
            send_char(CH_EQ);
            send_char(CH_GT);
        end else if (sel < 94) begin
            c = 8'($urandom_range(0, 255));
            send_char(c);
        end else if (sel < 98) begin
            send_char(CH_EQ);
            c = 8'($urandom_range(0, 255));
            send_char(c);
        end else begin
            send_char(CH_DOT);
        end
        if ($urandom_range(0, 9) < 3) begin
            n = $urandom_range(8, 13);
            send_char(n == 8 ? CH_SPACE : 8'(n));
        end
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (pending_words.size() == 0) begin
            if (fail_count < 10) begin
                $display("unexpected word %h at cycle %0d", got, cycles);
            end
            fail_count++;
        end else begin
            want = pending_words.pop_front();
            if (got.result_kind !== want.result_kind || got.token_class !== want.token_class ||
                got.out_char !== want.out_char || got.first_of_token !== want.first_of_token ||
                got.closes_token !== want.closes_token || got.error_code !== want.error_code ||
                got.line_number !== want.line_number || got.last_result !== want.last_result)
            begin
                if (fail_count < 10) begin
                    $display("mismatch at cycle %0d: kind %0d/%0d class %0d/%0d char %h/%h",
                             cycles, want.result_kind, got.result_kind, want.token_class,
                             got.token_class, want.out_char, got.out_char);
                    $display("  first %b/%b closes %b/%b err %0d/%0d line %0d/%0d last %b/%b",
                             want.first_of_token, got.first_of_token, want.closes_token,
                             got.closes_token, want.error_code, got.error_code,
                             want.line_number, got.line_number, want.last_result,
                             got.last_result);
                end
                fail_count++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_word(out_word);
        end
    end

    always @(posedge clk) begin
        if (no_idle) begin
            out_ready  <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 3) != 0) begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
        end else begin
            out_ready  <= 1'b0;
            ready_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row row;
        int   target;
        logic [7:0] c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_row(i);
            send_word({row.ch, 1'b0}, row.typed, row.want);
        end

        target = productive_chars + N_RANDOM;
        while (productive_chars < target) begin
            if ($urandom_range(0, 49) == 0) begin
                no_idle = !no_idle;
            end
            send_token();
        end
        no_idle = 1'b0;

        case ($urandom_range(0, 4))
            0: begin
                send_char("1");
                send_char("2");
            end
            1: begin
                send_char("3");
                send_char(CH_DOT);
            end
            2: begin
                send_char("a");
                send_char("b");
            end
            3: send_char(CH_EQ);
            default: ;
        endcase
        c = 8'($urandom_range(0, 255));
        send_word({c, 1'b1}, 1'b0, '0);
        repeat ($urandom_range(3, 6)) begin
            c = 8'($urandom_range(0, 255));
            send_word({c, 1'($urandom_range(0, 1))}, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_words.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
sv/gts_pkg.sv
sv/gts_front.sv
sv/gts_queue.sv
sv/gts_back.sv
sv/grammar_token_scanner_core.sv
sv/gts_checker.sv
tb/tb_grammar_token_scanner_core.sv
